@@ src/tsafp_pkg.sv @@
// Shared constants and types of the transport stream adaptation field parser.
package tsafp_pkg;

    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int unsigned CLOCK_RATIO = 300;

    localparam int unsigned CLK_BASE_W  = 33;
    localparam int unsigned CLK_EXT_W   = 9;
    localparam int unsigned CLK_VALUE_W = 42;

    // One parsed adaptation field, with clock references still in raw base and extension form.
    typedef struct packed {
        logic [7:0]             flag_bits;
        logic [CLK_BASE_W-1:0]  pcr_clk_base;
        logic [CLK_EXT_W-1:0]   pcr_ext;
        logic [CLK_BASE_W-1:0]  opcr_clk_base;
        logic [CLK_EXT_W-1:0]   opcr_ext;
        logic [7:0]             splice_cnt;
        logic [7:0]             private_length;
        logic                   ltw_valid;
        logic [14:0]            ltw_ofs;
        logic [21:0]            pw_rate;
        logic [3:0]             splice_kind;
        logic [32:0]            dts_next_au;
        logic [7:0]             stuff_cnt;
        logic                   status;
    } t_record;

    typedef struct packed {
        logic    valid;
        t_record rec;
    } t_push;

    typedef struct packed {
        logic [7:0]             flag_bits;
        logic [CLK_VALUE_W-1:0] pcr_value;
        logic [CLK_VALUE_W-1:0] opcr_value;
        logic [7:0]             splice_cnt;
        logic [7:0]             private_length;
        logic                   ltw_valid;
        logic [14:0]            ltw_ofs;
        logic [21:0]            pw_rate;
        logic [3:0]             splice_kind;
        logic [32:0]            dts_next_au;
        logic [7:0]             stuff_cnt;
        logic                   status;
    } t_result;

endpackage

@@ src/tsafp_front.sv @@
// Byte-level front end: tracks the section layout and assembles the fields of one adaptation field.
module tsafp_front import tsafp_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_data_byte,
    input  logic       i_first_byte,
    input  logic       i_queue_full,
    output t_push      o_push
);

    typedef enum logic [3:0] {
        PH_IDLE   = 4'd0,
        PH_FLAGS  = 4'd1,
        PH_PCR    = 4'd2,
        PH_OPCR   = 4'd3,
        PH_SPLICE = 4'd4,
        PH_PLEN   = 4'd5,
        PH_PDATA  = 4'd6,
        PH_XLEN   = 4'd7,
        PH_XFLAGS = 4'd8,
        PH_LTW    = 4'd9,
        PH_RATE   = 4'd10,
        PH_SEAM   = 4'd11,
        PH_XSKIP  = 4'd12,
        PH_STUFF  = 4'd13
    } t_phase;

    t_phase                r_phase, n_phase;
    logic [7:0]            r_field_length, n_field_length;
    logic [7:0]            r_byte_pos, n_byte_pos;
    logic [7:0]            r_left, n_left;
    logic [47:0]           r_acc, n_acc;
    logic [7:0]            r_flags, n_flags;
    logic [2:0]            r_xflags, n_xflags;
    logic [CLK_BASE_W-1:0] r_pcr_base, n_pcr_base;
    logic [CLK_EXT_W-1:0]  r_pcr_ext, n_pcr_ext;
    logic [CLK_BASE_W-1:0] r_opcr_base, n_opcr_base;
    logic [CLK_EXT_W-1:0]  r_opcr_ext, n_opcr_ext;
    logic [7:0]            r_splice, n_splice;
    logic [7:0]            r_plen, n_plen;
    logic [15:0]           r_ltw, n_ltw;
    logic [21:0]           r_rate, n_rate;
    logic [3:0]            r_stype, n_stype;
    logic [32:0]           r_dts, n_dts;
    logic [7:0]            r_ext_len, n_ext_len;
    logic [7:0]            r_ext_left, n_ext_left;
    logic                  r_ext_ovr, n_ext_ovr;
    logic [7:0]            r_used, n_used;

    logic        accept;
    logic [47:0] acc_shift;
    logic [3:0]  start_phase;
    t_phase      sel_phase;
    logic [7:0]  sel_size;
    logic        push;
    logic        done;

    function automatic logic [7:0] f_size(
        input t_phase     ph,
        input logic [7:0] flags,
        input logic [7:0] plen,
        input logic [7:0] xlen,
        input logic [2:0] xflags,
        input logic [7:0] xleft
    );
        logic [7:0] sz;
        sz = 8'd0;
        case (ph)
            PH_FLAGS:  sz = 8'd1;
            PH_PCR:    sz = flags[4] ? 8'd6 : 8'd0;
            PH_OPCR:   sz = flags[3] ? 8'd6 : 8'd0;
            PH_SPLICE: sz = flags[2] ? 8'd1 : 8'd0;
            PH_PLEN:   sz = flags[1] ? 8'd1 : 8'd0;
            PH_PDATA:  sz = flags[1] ? plen : 8'd0;
            PH_XLEN:   sz = flags[0] ? 8'd1 : 8'd0;
            PH_XFLAGS: sz = (flags[0] && xlen != 8'd0) ? 8'd1 : 8'd0;
            PH_LTW:    sz = xflags[2] ? 8'd2 : 8'd0;
            PH_RATE:   sz = xflags[1] ? 8'd3 : 8'd0;
            PH_SEAM:   sz = xflags[0] ? 8'd5 : 8'd0;
            PH_XSKIP:  sz = flags[0] ? xleft : 8'd0;
            default:   sz = 8'd0;
        endcase
        return sz;
    endfunction

    assign o_ready = !i_queue_full;
    assign accept  = i_valid && o_ready;

    always_comb begin
        n_phase        = r_phase;
        n_field_length = r_field_length;
        n_byte_pos     = r_byte_pos;
        n_left         = r_left;
        n_acc          = r_acc;
        n_flags        = r_flags;
        n_xflags       = r_xflags;
        n_pcr_base     = r_pcr_base;
        n_pcr_ext      = r_pcr_ext;
        n_opcr_base    = r_opcr_base;
        n_opcr_ext     = r_opcr_ext;
        n_splice       = r_splice;
        n_plen         = r_plen;
        n_ltw          = r_ltw;
        n_rate         = r_rate;
        n_stype        = r_stype;
        n_dts          = r_dts;
        n_ext_len      = r_ext_len;
        n_ext_left     = r_ext_left;
        n_ext_ovr      = r_ext_ovr;
        n_used         = r_used;
        acc_shift      = {r_acc[39:0], i_data_byte};
        start_phase    = 4'(r_phase + 4'd1);
        sel_phase      = PH_STUFF;
        sel_size       = 8'd0;
        push           = 1'b0;
        done           = 1'b0;

        if (accept) begin
            if (i_first_byte) begin
                n_byte_pos     = 8'd0;
                n_phase        = PH_IDLE;
                n_left         = 8'd0;
                n_acc          = '0;
                n_flags        = 8'd0;
                n_xflags       = 3'd0;
                n_pcr_base     = '0;
                n_pcr_ext      = '0;
                n_opcr_base    = '0;
                n_opcr_ext     = '0;
                n_splice       = 8'd0;
                n_plen         = 8'd0;
                n_ltw          = 16'd0;
                n_rate         = 22'd0;
                n_stype        = 4'd0;
                n_dts          = 33'd0;
                n_ext_len      = 8'd0;
                n_ext_left     = 8'd0;
                n_ext_ovr      = 1'b0;
                n_used         = 8'd0;
                n_field_length = i_data_byte;
                if (i_data_byte == 8'd0) begin
                    push = 1'b1;
                    done = 1'b1;
                end else begin
                    n_phase = PH_FLAGS;
                    n_left  = 8'd1;
                end
            end else if (r_phase != PH_IDLE) begin
                n_byte_pos = r_byte_pos + 8'd1;
                if (r_phase != PH_STUFF) begin
                    if (r_phase >= PH_XFLAGS) begin
                        if (r_ext_left == 8'd0) begin
                            n_ext_ovr = 1'b1;
                        end else begin
                            n_ext_left = r_ext_left - 8'd1;
                        end
                    end
                    n_acc  = acc_shift;
                    n_left = r_left - 8'd1;
                    if (r_left == 8'd1) begin
                        case (r_phase)
                            PH_FLAGS:  n_flags = i_data_byte;
                            PH_PCR: begin
                                n_pcr_base = acc_shift[47:15];
                                n_pcr_ext  = acc_shift[8:0];
                            end
                            PH_OPCR: begin
                                n_opcr_base = acc_shift[47:15];
                                n_opcr_ext  = acc_shift[8:0];
                            end
                            PH_SPLICE: n_splice = i_data_byte;
                            PH_PLEN:   n_plen = i_data_byte;
                            PH_XLEN: begin
                                n_ext_len  = i_data_byte;
                                n_ext_left = i_data_byte;
                            end
                            PH_XFLAGS: n_xflags = i_data_byte[7:5];
                            PH_LTW:    n_ltw = acc_shift[15:0];
                            PH_RATE:   n_rate = acc_shift[21:0];
                            PH_SEAM: begin
                                n_stype = acc_shift[39:36];
                                n_dts   = {acc_shift[35:33], acc_shift[31:17], acc_shift[15:1]};
                            end
                            default: begin
                            end
                        endcase
                        for (int p = int'(PH_XSKIP); p >= int'(PH_FLAGS); p--) begin
                            if (4'(p) >= start_phase &&
                                f_size(t_phase'(4'(p)), n_flags, n_plen, n_ext_len,
                                       n_xflags, n_ext_left) != 8'd0) begin
                                sel_phase = t_phase'(4'(p));
                                sel_size  = f_size(t_phase'(4'(p)), n_flags, n_plen, n_ext_len,
                                                   n_xflags, n_ext_left);
                            end
                        end
                        n_phase = sel_phase;
                        n_left  = sel_size;
                        n_acc   = '0;
                        if (sel_phase == PH_STUFF) begin
                            n_used = n_byte_pos;
                        end
                    end
                end
                if (n_byte_pos == r_field_length) begin
                    push    = 1'b1;
                    done    = (n_phase == PH_STUFF) && !n_ext_ovr;
                    n_phase = PH_IDLE;
                end
            end
        end

        o_push.valid              = push;
        o_push.rec.flag_bits      = n_flags;
        o_push.rec.pcr_clk_base   = n_pcr_base;
        o_push.rec.pcr_ext        = n_pcr_ext;
        o_push.rec.opcr_clk_base  = n_opcr_base;
        o_push.rec.opcr_ext       = n_opcr_ext;
        o_push.rec.splice_cnt     = n_splice;
        o_push.rec.private_length = n_plen;
        o_push.rec.ltw_valid      = n_ltw[15];
        o_push.rec.ltw_ofs        = n_ltw[14:0];
        o_push.rec.pw_rate        = n_rate;
        o_push.rec.splice_kind    = n_stype;
        o_push.rec.dts_next_au    = n_dts;
        o_push.rec.stuff_cnt      = done ? 8'(n_field_length - n_used) : 8'd0;
        o_push.rec.status         = !done;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_IDLE;
            r_field_length <= 8'd0;
            r_byte_pos     <= 8'd0;
            r_left         <= 8'd0;
            r_acc          <= '0;
            r_flags        <= 8'd0;
            r_xflags       <= 3'd0;
            r_pcr_base     <= '0;
            r_pcr_ext      <= '0;
            r_opcr_base    <= '0;
            r_opcr_ext     <= '0;
            r_splice       <= 8'd0;
            r_plen         <= 8'd0;
            r_ltw          <= 16'd0;
            r_rate         <= 22'd0;
            r_stype        <= 4'd0;
            r_dts          <= 33'd0;
            r_ext_len      <= 8'd0;
            r_ext_left     <= 8'd0;
            r_ext_ovr      <= 1'b0;
            r_used         <= 8'd0;
        end else begin
            r_phase        <= n_phase;
            r_field_length <= n_field_length;
            r_byte_pos     <= n_byte_pos;
            r_left         <= n_left;
            r_acc          <= n_acc;
            r_flags        <= n_flags;
            r_xflags       <= n_xflags;
            r_pcr_base     <= n_pcr_base;
            r_pcr_ext      <= n_pcr_ext;
            r_opcr_base    <= n_opcr_base;
            r_opcr_ext     <= n_opcr_ext;
            r_splice       <= n_splice;
            r_plen         <= n_plen;
            r_ltw          <= n_ltw;
            r_rate         <= n_rate;
            r_stype        <= n_stype;
            r_dts          <= n_dts;
            r_ext_len      <= n_ext_len;
            r_ext_left     <= n_ext_left;
            r_ext_ovr      <= n_ext_ovr;
            r_used         <= n_used;
        end
    end

    a_pos_within_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase != PH_IDLE) |-> (r_byte_pos < r_field_length))
        else $error("Byte position reached the field length without closing the field.");

    a_idle_no_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && !i_first_byte && r_phase == PH_IDLE) |-> !push)
        else $error("A byte outside a field produced a transaction.");

endmodule

@@ src/tsafp_queue.sv @@
// Short queue of parsed field records between the front end and the back end.
module tsafp_queue import tsafp_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_push   i_push,
    output logic    o_full,
    output logic    o_valid,
    output t_record o_data,
    input  logic    i_pop
);

    t_record             r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr_ptr;
    logic [QUEUE_AW-1:0] r_rd_ptr;
    logic [QUEUE_AW:0]   r_count;

    logic do_push;
    logic do_pop;

    assign o_full  = (r_count == (QUEUE_AW + 1)'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push.valid && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push.rec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + QUEUE_AW'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + QUEUE_AW'(1);
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + (QUEUE_AW + 1)'(1);
                2'b01:   r_count <= r_count - (QUEUE_AW + 1)'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push.valid |-> !o_full)
        else $error("Transaction pushed into a full queue.");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (QUEUE_AW + 1)'(QUEUE_DEPTH))
        else $error("Queue occupancy exceeds its depth.");

    a_empty_pointers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> (r_wr_ptr == r_rd_ptr))
        else $error("Empty queue with unequal pointers.");

endmodule

@@ src/tsafp_back.sv @@
// Back end: scales the clock references and holds the result for the output channel.
module tsafp_back import tsafp_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  t_record i_data,
    output logic    o_pop,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_result
);

    logic                   r_s1_valid;
    t_record                r_s1;
    logic [CLK_VALUE_W-1:0] r_s1_pcr_scaled;
    logic [CLK_VALUE_W-1:0] r_s1_opcr_scaled;
    logic                   r_out_valid;
    t_result                r_out;

    logic out_load;
    logic s1_load;

    assign out_load = r_s1_valid && (!r_out_valid || i_ready);
    assign s1_load  = i_valid && (!r_s1_valid || out_load);
    assign o_pop    = s1_load;
    assign o_valid  = r_out_valid;
    assign o_result = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s1_load) begin
                r_s1_valid <= 1'b1;
            end else if (out_load) begin
                r_s1_valid <= 1'b0;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_load) begin
            r_s1             <= i_data;
            r_s1_pcr_scaled  <= CLK_VALUE_W'(i_data.pcr_clk_base) * CLK_VALUE_W'(CLOCK_RATIO);
            r_s1_opcr_scaled <= CLK_VALUE_W'(i_data.opcr_clk_base) * CLK_VALUE_W'(CLOCK_RATIO);
        end
        if (out_load) begin
            r_out.flag_bits      <= r_s1.flag_bits;
            r_out.pcr_value      <= r_s1_pcr_scaled + CLK_VALUE_W'(r_s1.pcr_ext);
            r_out.opcr_value     <= r_s1_opcr_scaled + CLK_VALUE_W'(r_s1.opcr_ext);
            r_out.splice_cnt     <= r_s1.splice_cnt;
            r_out.private_length <= r_s1.private_length;
            r_out.ltw_valid      <= r_s1.ltw_valid;
            r_out.ltw_ofs        <= r_s1.ltw_ofs;
            r_out.pw_rate        <= r_s1.pw_rate;
            r_out.splice_kind    <= r_s1.splice_kind;
            r_out.dts_next_au    <= r_s1.dts_next_au;
            r_out.stuff_cnt      <= r_s1.stuff_cnt;
            r_out.status         <= r_s1.status;
        end
    end

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_out_valid && !i_ready) |-> !o_pop)
        else $error("Scaling stage loaded while both stages were stalled.");

endmodule

@@ src/ts_adaptation_field_parser_unit.sv @@
// Top level of the transport stream adaptation field parser.
// Input channel: one adaptation field byte per transaction on i_data_byte, with
// i_first_byte set on the length byte that opens a field. A transaction
// completes when i_valid and o_ready are both high at a rising edge.
// Output channel: one result per field on the o_* field ports, a transaction
// completing when o_valid and i_ready are both high.
// Throughput is one byte per cycle while the queue is not full; the front end
// handles each byte as it is accepted, and the back end takes one result per
// cycle while the receiver takes its results.
// After the edge that accepts the last byte of the field (or a zero length
// byte), the result passes through the record queue, the clock reference
// scaling stage and then the output register, where o_valid rises.
// When the receiver stalls, results wait in the output register, the scaling
// stage and a four-entry queue; o_ready falls only when the queue is full.
// Synchronous reset clears the parse state, the queue and both back-end stages;
// the block accepts bytes in the first cycle after reset is released.
module ts_adaptation_field_parser_unit import tsafp_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic [7:0]             i_data_byte,
    input  logic                   i_first_byte,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic [7:0]             o_flag_bits,
    output logic [CLK_VALUE_W-1:0] o_pcr_value,
    output logic [CLK_VALUE_W-1:0] o_opcr_value,
    output logic signed [7:0]      o_splice_countdown,
    output logic [7:0]             o_private_length,
    output logic                   o_ltw_valid,
    output logic [14:0]            o_ltw_offset,
    output logic [21:0]            o_piecewise_rate,
    output logic [3:0]             o_splice_type,
    output logic [32:0]            o_dts_next_au,
    output logic [7:0]             o_stuffing_count,
    output logic                   o_status
);

    t_push   push;
    logic    queue_full;
    logic    queue_valid;
    t_record queue_data;
    logic    queue_pop;
    t_result result;

    tsafp_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_data_byte  (i_data_byte),
        .i_first_byte (i_first_byte),
        .i_queue_full (queue_full),
        .o_push       (push)
    );

    tsafp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_full  (queue_full),
        .o_valid (queue_valid),
        .o_data  (queue_data),
        .i_pop   (queue_pop)
    );

    tsafp_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (queue_valid),
        .i_data   (queue_data),
        .o_pop    (queue_pop),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .o_result (result)
    );

    assign o_flag_bits        = result.flag_bits;
    assign o_pcr_value        = result.pcr_value;
    assign o_opcr_value       = result.opcr_value;
    assign o_splice_countdown = $signed(result.splice_cnt);
    assign o_private_length   = result.private_length;
    assign o_ltw_valid        = result.ltw_valid;
    assign o_ltw_offset       = result.ltw_ofs;
    assign o_piecewise_rate   = result.pw_rate;
    assign o_splice_type      = result.splice_kind;
    assign o_dts_next_au      = result.dts_next_au;
    assign o_stuffing_count   = result.stuff_cnt;
    assign o_status           = result.status;

endmodule
